// File: rtl/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants and helpers for the Taylor-series cosine block.
// ----------------------------------------------------------------------------
package tcs_pkg;
	localparam int FRAC_BITS = 26;
	localparam int MAX_TERMS = 32;
	localparam int ANGLE_W   = 30;
	localparam int COS_W     = 32;
	localparam int CNT_W     = 6;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int NUM_W     = 64;
	localparam int QUO_W     = NUM_W - FRAC_BITS;
	localparam int DEN_W     = 12;
	localparam int TERM_W    = 31;
	localparam logic [CNT_W-1:0] TERM_COUNT_RESET = CNT_W'(8);

	// Divisor (2i)(2i-1) of term i.
	function automatic logic [DEN_W-1:0] term_den(input logic [CNT_W-1:0] i);
		logic [DEN_W-1:0] two_i;
		two_i = {{(DEN_W-CNT_W-1){1'b0}}, i, 1'b0};
		return DEN_W'(two_i * (two_i - DEN_W'(1)));
	endfunction
endpackage

// File: rtl/taylor_cosine_series.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_cosine_series
// Sums N Taylor terms of the cosine of a Q4.26 angle, with saturation flag.
// ----------------------------------------------------------------------------
// The angle is squared once; then each further term takes a multiply, a divide and an add.
// A new angle is accepted only in idle, once the previous result has gone to the output
// register; the serial multiplier and the serial divider are shared by every term.
// A finished result waits in the output register while the next angle starts.
// Reset clears all control state and sets the term count to 8.
module taylor_cosine_series (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [29:0] angle, [31:30] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] cosine
	output logic [0:0]  m_axis_tuser    // [0] saturated
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_MUL, ST_DIV, ST_ACC, ST_OUT, ST_ADD
	} state_t;

	localparam int W = tcs_pkg::COS_W;
	localparam logic signed [W+1:0] SUM_HI = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SUM_LO = {3'b111, {(W-1){1'b0}}};

	state_t                         state_q;
	logic [tcs_pkg::CNT_W-1:0]      term_count_q;
	logic [tcs_pkg::CNT_W-1:0]      n_q;
	logic [tcs_pkg::CNT_W-1:0]      idx_q;
	logic [tcs_pkg::MUL_W-1:0]      x2_q;
	logic [tcs_pkg::TERM_W-1:0]     term_q;
	logic signed [W-1:0]            sum_q;
	logic                           sat_q;
	logic                           mul_start_q;
	logic                           div_start_q;
	logic [tcs_pkg::MUL_W-1:0]      mul_a_q;
	logic [tcs_pkg::MUL_W-1:0]      mul_b_q;
	logic [tcs_pkg::QUO_W-1:0]      div_num_q;
	logic [31:0]                    out_cos_q;
	logic                           out_sat_q;
	logic                           out_valid_q;

	logic                           mul_done;
	logic [tcs_pkg::PROD_W-1:0]     prod;
	logic                           div_done;
	logic [tcs_pkg::QUO_W-1:0]      quo;
	logic signed [tcs_pkg::ANGLE_W-1:0] angle;
	logic [tcs_pkg::ANGLE_W-1:0]    ax;
	logic [tcs_pkg::CNT_W-1:0]      n_clip;
	logic [tcs_pkg::PROD_W-1:0]     x2_full;
	logic [tcs_pkg::NUM_W-1:0]      num_rnd;
	logic [tcs_pkg::DEN_W-1:0]      den;
	logic signed [W+1:0]            sum_next;
	logic                           mul_go;
	logic                           div_go;
	logic                           out_load;

	assign angle  = s_axis_tdata[tcs_pkg::ANGLE_W-1:0];
	assign ax     = angle[tcs_pkg::ANGLE_W-1] ? tcs_pkg::ANGLE_W'(-angle) : angle;
	assign n_clip = (term_count_q > tcs_pkg::CNT_W'(tcs_pkg::MAX_TERMS))
		? tcs_pkg::CNT_W'(tcs_pkg::MAX_TERMS) : term_count_q;
	assign x2_full = (prod + (tcs_pkg::PROD_W'(1) << (tcs_pkg::FRAC_BITS - 1)))
		>> tcs_pkg::FRAC_BITS;
	assign den     = tcs_pkg::term_den(idx_q);
	assign num_rnd = prod[tcs_pkg::NUM_W-1:0]
		+ (tcs_pkg::NUM_W'(den) << (tcs_pkg::FRAC_BITS - 1));

	assign mul_go = ((state_q == ST_IDLE) && s_axis_tvalid)
		|| ((state_q == ST_ACC) && (n_q != '0) && (idx_q != n_q));
	assign div_go   = (state_q == ST_MUL) && mul_done;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		if (idx_q[0]) begin
			sum_next = (W+2)'(sum_q) - $signed({3'b000, term_q});
		end else begin
			sum_next = (W+2)'(sum_q) + $signed({3'b000, term_q});
		end
	end

	tcs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (prod)
	);

	tcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (den),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			term_count_q <= tcs_pkg::TERM_COUNT_RESET;
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_cos_q    <= '0;
			out_sat_q    <= 1'b0;
			n_q          <= '0;
			idx_q        <= '0;
			x2_q         <= '0;
			term_q       <= '0;
			sum_q        <= '0;
			sat_q        <= 1'b0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			div_num_q    <= '0;
		end else begin
			mul_start_q <= mul_go;
			div_start_q <= div_go;
			if (cfg_valid) begin
				term_count_q <= cfg_data;
			end
			if (out_load) begin
				out_cos_q   <= sum_q;
				out_sat_q   <= sat_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						n_q         <= n_clip;
						mul_a_q     <= tcs_pkg::MUL_W'(ax);
						mul_b_q     <= tcs_pkg::MUL_W'(ax);
						sat_q       <= 1'b0;
						state_q     <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						if (x2_full > (tcs_pkg::PROD_W'(1) << 32)) begin
							x2_q  <= tcs_pkg::MUL_W'(1) << 32;
							sat_q <= n_q > tcs_pkg::CNT_W'(1);
						end else begin
							x2_q <= x2_full[tcs_pkg::MUL_W-1:0];
						end
						term_q  <= tcs_pkg::TERM_W'(1) << tcs_pkg::FRAC_BITS;
						sum_q   <= (n_q == '0) ? '0 : W'(1) << tcs_pkg::FRAC_BITS;
						idx_q   <= tcs_pkg::CNT_W'(1);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (n_q == '0 || idx_q == n_q) begin
						state_q <= ST_OUT;
					end else begin
						mul_a_q     <= tcs_pkg::MUL_W'(term_q);
						mul_b_q     <= x2_q;
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						div_num_q   <= num_rnd[tcs_pkg::NUM_W-1:tcs_pkg::FRAC_BITS];
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (quo > tcs_pkg::QUO_W'({tcs_pkg::TERM_W{1'b1}})) begin
							term_q <= {tcs_pkg::TERM_W{1'b1}};
							sat_q  <= 1'b1;
						end else begin
							term_q <= quo[tcs_pkg::TERM_W-1:0];
						end
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// Odd terms are subtracted, even terms added.
					if (sum_next > SUM_HI) begin
						sum_q <= SUM_HI[W-1:0];
						sat_q <= 1'b1;
					end else if (sum_next < SUM_LO) begin
						sum_q <= SUM_LO[W-1:0];
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_next[W-1:0];
					end
					idx_q   <= idx_q + tcs_pkg::CNT_W'(1);
					state_q <= ST_ACC;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_cos_q;
	assign m_axis_tuser  = out_sat_q;
endmodule

// File: rtl/tcs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcs_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tcs_pkg::MUL_W-1:0]      a,
	input  logic [tcs_pkg::MUL_W-1:0]      b,
	output logic                           done,
	output logic [tcs_pkg::PROD_W-1:0]     p
);
	logic [tcs_pkg::PROD_W-1:0] acc_q;
	logic [tcs_pkg::MUL_W-1:0]  a_q;
	logic [tcs_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tcs_pkg::MUL_W:0]    upper;
	logic                       last;

	always_comb begin
		upper = {1'b0, acc_q[tcs_pkg::PROD_W-1:tcs_pkg::MUL_W]};
		if (acc_q[0]) begin
			upper = upper + {1'b0, a_q};
		end
	end

	assign last = (cnt_q == tcs_pkg::CNT_W'(tcs_pkg::MUL_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + tcs_pkg::CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{tcs_pkg::MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {upper, acc_q[tcs_pkg::MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

// File: rtl/tcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tcs_pkg::QUO_W-1:0]     dividend,
	input  logic [tcs_pkg::DEN_W-1:0]     divisor,
	output logic                          done,
	output logic [tcs_pkg::QUO_W-1:0]     quotient
);
	logic [tcs_pkg::QUO_W-1:0] quo_q;
	logic [tcs_pkg::DEN_W-1:0] rem_q;
	logic [tcs_pkg::DEN_W-1:0] den_q;
	logic [tcs_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [tcs_pkg::DEN_W:0]   trial;
	logic                      ge;
	logic                      last;

	assign trial = {rem_q, quo_q[tcs_pkg::QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign last  = (cnt_q == tcs_pkg::CNT_W'(tcs_pkg::QUO_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + tcs_pkg::CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? tcs_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[tcs_pkg::DEN_W-1:0];
			quo_q <= {quo_q[tcs_pkg::QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
